// ===== design/path_token_alias_matcher_defines.svh =====
// assertion macros for the path token alias matcher top-level design file
`ifndef PATH_TOKEN_ALIAS_MATCHER_DEFINES_SVH
`define PATH_TOKEN_ALIAS_MATCHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptam_pkg.sv =====
// shared types, constants and helpers for the path token alias matcher
package ptam_pkg;

    // default sizing
    localparam int MAX_ALIASES_DEF   = 10;
    localparam int MAX_ALIAS_LEN_DEF = 50;

    // fixed field widths
    localparam int CHAR_W = 8;
    localparam int TPOS_W = 6;

    localparam logic [TPOS_W-1:0] TPOS_MAX   = 6'd63;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TEND,
        ST_EMIT
    } t_state;

    // compare unit operation
    typedef enum logic {
        CMP_CHAR,
        CMP_LEN
    } t_cmp_mode;

    typedef struct packed {
        t_cmp_mode         mode;
        logic [CHAR_W-1:0] char_a;
        logic [CHAR_W-1:0] char_b;
        logic [TPOS_W-1:0] len;
        logic [TPOS_W-1:0] tpos;
        logic              sm_bit;
    } t_cmp_req;

    // path delimiter set !@#$%^&*()-+/<>,|
    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        logic r;
        case (c) inside
            8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28,
            8'h29, 8'h2d, 8'h2b, 8'h2f, 8'h3c, 8'h3e, 8'h2c, 8'h7c: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ptam_mem.sv =====
// alias text memory: one write port, one registered read port
module ptam_mem #(
    parameter int DEPTH = ptam_pkg::MAX_ALIASES_DEF * ptam_pkg::MAX_ALIAS_LEN_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [ptam_pkg::CHAR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [ptam_pkg::CHAR_W-1:0] o_rdata
);
    import ptam_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptam_cmp.sv =====
// shared compare unit: character match against an alias or token length check
module ptam_cmp (
    input  ptam_pkg::t_cmp_req i_req,
    output logic               o_hit
);
    import ptam_pkg::*;

    // character mode keeps an alias alive, length mode finds a whole match
    always_comb begin
        unique case (i_req.mode)
            CMP_CHAR: o_hit = (i_req.tpos < i_req.len) && (i_req.char_a == i_req.char_b);
            CMP_LEN:  o_hit = i_req.sm_bit && (i_req.len == i_req.tpos);
            default:  o_hit = 1'b0;
        endcase
    end

endmodule

// ===== design/path_token_alias_matcher.sv =====
// path token alias matcher: an alias list byte is stored in its accept cycle; a path byte is
// accepted and then scanned against every stored alias; a delimiter is accepted and then closes
// the token, looking for a live alias of the token's length; a last path byte that is no
// delimiter adds a token end, and every last path byte adds a result state, held while the
// result beat is stalled. Input is stalled while a byte is in work.
// Synchronous active-low reset empties the alias list and path state; alias text is not cleared.
`include "path_token_alias_matcher_defines.svh"

module path_token_alias_matcher #(
    parameter int MAX_ALIASES   = ptam_pkg::MAX_ALIASES_DEF,
    parameter int MAX_ALIAS_LEN = ptam_pkg::MAX_ALIAS_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [ptam_pkg::CHAR_W-1:0] i_char_in,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_match
);
    import ptam_pkg::*;

    localparam int DEPTH = MAX_ALIASES * MAX_ALIAS_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_ALIASES + 1);
    localparam int IW    = (MAX_ALIASES > 1) ? $clog2(MAX_ALIASES) : 1;

    localparam logic [CW-1:0]     MAXC = CW'(MAX_ALIASES);
    localparam logic [TPOS_W-1:0] LENC = TPOS_W'(MAX_ALIAS_LEN);
    localparam logic [AW-1:0]     LENA = AW'(MAX_ALIAS_LEN);

    t_state r_state, n_state;

    // alias list state
    logic [CW-1:0]     r_count, n_count;
    logic [TPOS_W-1:0] r_lp, n_lp;
    logic [AW-1:0]     r_wbase, n_wbase;
    logic              r_list_done, n_list_done;
    logic [TPOS_W-1:0] r_len [MAX_ALIASES];
    logic [TPOS_W-1:0] n_len [MAX_ALIASES];

    // path state
    logic [MAX_ALIASES-1:0] r_sm, n_sm;
    logic [TPOS_W-1:0]      r_tpos, n_tpos;
    logic                   r_found, n_found;

    // sequencer working registers
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pv, n_pv;
    logic [IW-1:0]     r_pi, n_pi;
    logic [AW-1:0]     r_rbase, n_rbase;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;

    // result register
    logic r_ovalid, n_ovalid;
    logic r_omatch, n_omatch;

    // memory and compare unit hookup
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;
    t_cmp_req          cmp_req;
    logic              cmp_hit;

    logic in_acc;
    logic scan_done;
    logic tend_done;
    logic out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign scan_done   = (r_idx == r_count) && !r_pv;
    assign tend_done   = (r_tpos == '0) || (r_idx == r_count);
    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_match     = r_omatch;

    ptam_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ptam_cmp u_cmp (
        .i_req (cmp_req),
        .o_hit (cmp_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_action) begin
                    n_state = is_delim(i_char_in) ? ST_TEND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = r_last ? ST_TEND : ST_IDLE;
                end
            end
            ST_TEND: begin
                if (tend_done) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // compare unit operands
    always_comb begin
        cmp_req.mode   = (r_state == ST_TEND) ? CMP_LEN : CMP_CHAR;
        cmp_req.char_a = mem_rdata;
        cmp_req.char_b = r_char;
        cmp_req.len    = (r_state == ST_TEND) ? r_len[r_idx[IW-1:0]] : r_len[r_pi];
        cmp_req.tpos   = r_tpos;
        cmp_req.sm_bit = r_sm[r_idx[IW-1:0]];
    end

    // datapath and outputs per state
    always_comb begin
        logic [CW-1:0]     v_cnt;
        logic [TPOS_W-1:0] v_lp;
        logic [AW-1:0]     v_wb;

        n_count     = r_count;
        n_lp        = r_lp;
        n_wbase     = r_wbase;
        n_list_done = r_list_done;
        n_len       = r_len;
        n_sm        = r_sm;
        n_tpos      = r_tpos;
        n_found     = r_found;
        n_idx       = r_idx;
        n_pv        = r_pv;
        n_pi        = r_pi;
        n_rbase     = r_rbase;
        n_char      = r_char;
        n_last      = r_last;
        n_ovalid    = r_ovalid && i_out_stall;
        n_omatch    = r_omatch;
        mem_we      = 1'b0;
        mem_waddr   = r_wbase;
        mem_wdata   = i_char_in;
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_rbase + AW'(r_tpos));
        v_cnt       = r_count;
        v_lp        = r_lp;
        v_wb        = r_wbase;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !i_action) begin
                    // alias list beat, a new list first drops the old one
                    if (r_list_done) begin
                        v_cnt       = '0;
                        v_lp        = '0;
                        v_wb        = '0;
                        n_sm        = '1;
                        n_tpos      = '0;
                        n_found     = 1'b0;
                        n_list_done = 1'b0;
                    end
                    if (i_char_in == CHAR_COMMA) begin
                        if (v_lp != '0 && v_cnt < MAXC) begin
                            v_cnt = v_cnt + 1'b1;
                            v_wb  = v_wb + LENA;
                        end
                        v_lp = '0;
                    end else if (v_cnt < MAXC && v_lp < LENC) begin
                        mem_we                 = 1'b1;
                        mem_waddr              = AW'(v_wb + AW'(v_lp));
                        v_lp                   = v_lp + 1'b1;
                        n_len[v_cnt[IW-1:0]]   = v_lp;
                    end
                    if (i_last) begin
                        if (v_lp != '0 && v_cnt < MAXC) begin
                            v_cnt = v_cnt + 1'b1;
                            v_wb  = v_wb + LENA;
                        end
                        v_lp        = '0;
                        n_list_done = 1'b1;
                    end
                    n_count = v_cnt;
                    n_lp    = v_lp;
                    n_wbase = v_wb;
                end else if (in_acc) begin
                    // path beat, start the alias sweep
                    n_char  = i_char_in;
                    n_last  = i_last;
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_rbase = '0;
                end
            end
            ST_SCAN: begin
                // issue one alias read per cycle, compare the previous one
                if (r_idx < r_count) begin
                    mem_re  = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_rbase = r_rbase + LENA;
                    n_pi    = r_idx[IW-1:0];
                end
                n_pv = (r_idx < r_count);
                if (r_pv && !cmp_hit) begin
                    n_sm[r_pi] = 1'b0;
                end
                if (scan_done) begin
                    n_idx = '0;
                    if (r_tpos != TPOS_MAX) begin
                        n_tpos = r_tpos + 1'b1;
                    end
                end
            end
            ST_TEND: begin
                // token end: look for a live alias of the token's length
                if (!tend_done) begin
                    if (cmp_hit) begin
                        n_found = 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx  = '0;
                    n_sm   = '1;
                    n_tpos = '0;
                end
            end
            ST_EMIT: begin
                // result beat, then fresh path state
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_omatch = r_found;
                    n_found  = 1'b0;
                    n_sm     = '1;
                    n_tpos   = '0;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_lp        <= '0;
            r_wbase     <= '0;
            r_list_done <= 1'b1;
            r_sm        <= '1;
            r_tpos      <= '0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lp        <= n_lp;
            r_wbase     <= n_wbase;
            r_list_done <= n_list_done;
            r_sm        <= n_sm;
            r_tpos      <= n_tpos;
            r_found     <= n_found;
            r_idx       <= n_idx;
            r_pv        <= n_pv;
            r_ovalid    <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_pi     <= n_pi;
        r_rbase  <= n_rbase;
        r_char   <= n_char;
        r_last   <= n_last;
        r_omatch <= n_omatch;
    end

    `PTAM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= MAXC, "alias count overflow")
    `PTAM_ASSERT_IMP(a_scan_idx, i_clk, i_rst_n, r_state == ST_SCAN, r_idx <= r_count, "scan index past alias count")
    `PTAM_ASSERT_IMP(a_emit_tpos, i_clk, i_rst_n, r_state == ST_EMIT, r_tpos == '0, "token not closed before result")
    `PTAM_ASSERT_NXT(a_emit_beat, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free, o_out_valid && (r_state == ST_IDLE), "result beat not loaded")

endmodule
